/* rtl/gcpd_pkg.sv */
// Shared types and constants for the grid cell point dedup block.
package gcpd_pkg;

    localparam int COORD_W = 24;
    localparam int TAG_W = 32;
    localparam int SCALE_W = 24;
    localparam int KEY_SHIFT = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [TAG_W-1:0]          point_tag;
        logic                      last_point;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
        logic signed [COORD_W-1:0] kept_z;
        logic [TAG_W-1:0]          kept_tag;
        logic                      end_of_list;
        logic                      overflowed;
    } t_point_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TAG_W-1:0]          tag;
    } t_entry;

    typedef struct packed {
        logic signed [COORD_W-1:0] key_x;
        logic signed [COORD_W-1:0] key_z;
        t_entry                    pt;
        logic                      last;
    } t_work;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_READ,
        ST_UPDATE,
        ST_EMIT
    } t_back_state;

endpackage

/* rtl/gcpd_front.sv */
// Front stage: accepts points, computes cell keys, hands work to the queue.
module gcpd_front
    import gcpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_point_in            i_point,
    input  logic                 i_cfg_we,
    input  logic [SCALE_W-1:0]   i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_work                o_work
);

    localparam int PROD_W = COORD_W + SCALE_W + 1;

    logic [SCALE_W-1:0]       r_scale;
    logic                     r_fv;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_pz;
    t_entry                   r_pt;
    logic                     r_last;
    logic                     accept;
    logic signed [SCALE_W:0]  scale_s;

    assign o_push  = r_fv && !i_q_full;
    assign busy    = r_fv && !o_push;
    assign accept  = start && !busy;
    assign scale_s = $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_fv    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_data;
            end
            if (accept) begin
                r_fv <= 1'b1;
            end else if (o_push) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= PROD_W'(i_point.pos_x * scale_s);
            r_pz   <= PROD_W'(i_point.pos_z * scale_s);
            r_pt   <= '{x: i_point.pos_x, y: i_point.pos_y, z: i_point.pos_z,
                        tag: i_point.point_tag};
            r_last <= i_point.last_point;
        end
    end

    assign o_work.key_x = r_px[KEY_SHIFT +: COORD_W];
    assign o_work.key_z = r_pz[KEY_SHIFT +: COORD_W];
    assign o_work.pt    = r_pt;
    assign o_work.last  = r_last;

endmodule

/* rtl/gcpd_queue.sv */
// Two-entry queue between front and back stages.
module gcpd_queue
    import gcpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_work o_work
);

    t_work       r_buf [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_work  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_work;
        end
    end

endmodule

/* rtl/gcpd_back.sv */
// Back stage: key match, table update and in-order emission of kept points.
module gcpd_back
    import gcpd_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_work      i_work,
    output logic       o_pop,
    output logic       o_valid,
    output t_point_out o_result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_back_state r_state;
    t_back_state n_state;

    logic signed [COORD_W-1:0] r_kx [TABLE_DEPTH];
    logic signed [COORD_W-1:0] r_kz [TABLE_DEPTH];
    t_entry                    r_mem [TABLE_DEPTH];

    t_work                   r_cur;
    logic [TABLE_DEPTH-1:0]  r_hitvec;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_hit;
    t_entry                  r_rd;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;
    logic [IDX_W-1:0]        r_eidx;
    logic                    r_ov;
    logic                    r_oend;
    logic                    r_oovf;

    logic [TABLE_DEPTH-1:0]  hitvec;
    logic [IDX_W-1:0]        enc_idx;
    logic                    full;
    logic                    emit_end;
    logic [IDX_W-1:0]        rd_addr;
    logic                    rd_en;
    logic                    upd_new;
    logic                    upd_rep;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hitvec[i] = (CNT_W'(i) < r_count) && (r_kx[i] == r_cur.key_x)
                        && (r_kz[i] == r_cur.key_z);
        end
    end

    always_comb begin
        enc_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            enc_idx = enc_idx | (r_hitvec[i] ? IDX_W'(i) : '0);
        end
    end

    assign full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign emit_end = (CNT_W'(r_eidx) + CNT_W'(1) == r_count);
    assign upd_rep  = (r_state == ST_UPDATE) && r_hit && (r_cur.pt.y > r_rd.y);
    assign upd_new  = (r_state == ST_UPDATE) && !r_hit && !full;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = enc_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                rd_en   = 1'b1;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = r_cur.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                rd_en   = 1'b1;
                rd_addr = r_eidx;
                if (emit_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= (r_state == ST_EMIT);
            if (upd_new) begin
                r_count <= r_count + CNT_W'(1);
            end
            if ((r_state == ST_UPDATE) && !r_hit && full) begin
                r_ovf <= 1'b1;
            end
            if (r_state == ST_EMIT) begin
                if (emit_end) begin
                    r_eidx  <= '0;
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_eidx <= r_eidx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_work;
        end
        if (r_state == ST_MATCH) begin
            r_hitvec <= hitvec;
            r_hit    <= |hitvec;
        end
        if (r_state == ST_READ) begin
            r_idx <= enc_idx;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
        if (upd_rep) begin
            r_mem[r_idx] <= r_cur.pt;
        end else if (upd_new) begin
            r_mem[r_count[IDX_W-1:0]] <= r_cur.pt;
        end
        if (upd_new) begin
            r_kx[r_count[IDX_W-1:0]] <= r_cur.key_x;
            r_kz[r_count[IDX_W-1:0]] <= r_cur.key_z;
        end
        if (r_state == ST_EMIT) begin
            r_oend <= emit_end;
            r_oovf <= r_ovf;
        end
    end

    assign o_valid              = r_ov;
    assign o_result.kept_x      = r_rd.x;
    assign o_result.kept_y      = r_rd.y;
    assign o_result.kept_z      = r_rd.z;
    assign o_result.kept_tag    = r_rd.tag;
    assign o_result.end_of_list = r_oend;
    assign o_result.overflowed  = r_oovf;

endmodule

/* rtl/grid_cell_point_dedup.sv */
// Grid cell point dedup top level: front stage, queue and back stage.
// A point reaches the table via the front register, the queue and the pop, match, read and update states.
// On a last point the kept points are then strobed in table order, one per cycle.
// The back stage finishes one point before popping the next, and pops nothing while emitting.
// Synchronous active-low reset clears control state and sets cell_scale to 1.0.
// Results are strobed for one cycle; the receiver cannot stall.
module grid_cell_point_dedup
    import gcpd_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_point_in          i_point,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_data,
    output logic               o_valid,
    output t_point_out         o_result
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_work f_work;
    t_work q_work;

    gcpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point    (i_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_work     (f_work)
    );

    gcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (f_work),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_work  (q_work)
    );

    gcpd_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_work    (q_work),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

endmodule

/* rtl/gcpd_checker.sv */
// Port-level checker for the grid cell point dedup block, with its bind.
module gcpd_checker
    import gcpd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input t_point_out o_result
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.end_of_list |=> o_valid)
        else $error("gap inside emitted list");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.end_of_list |=> !o_valid)
        else $error("result after end of list");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && !$past(o_result.end_of_list)
        |-> o_result.overflowed == $past(o_result.overflowed))
        else $error("overflow flag changed within a list");

endmodule

bind grid_cell_point_dedup gcpd_checker u_gcpd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .o_result (o_result)
);
